>>> rtl/core/bf7_pkg.sv
package bf7_pkg;

  // Window geometry
  localparam int WINDOW     = 7;
  localparam int HALF       = WINDOW / 2;
  localparam int LINE_DEPTH = WINDOW - 1;
  localparam int AREA       = WINDOW * WINDOW;

  // Image limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Data widths
  localparam int PIX_W   = 8;
  localparam int PIX_MAX = (1 << PIX_W) - 1;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int CSUM_W  = $clog2(WINDOW * PIX_MAX + 1);
  localparam int TOTAL_W = $clog2(AREA * PIX_MAX + 1);
  localparam int LINE_W  = LINE_DEPTH * PIX_W;

  // Configuration registers
  localparam int WREG_W  = 11;
  localparam int HREG_W  = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [WREG_W-1:0] WREG_RESET = WREG_W'(640);
  localparam logic [HREG_W-1:0] HREG_RESET = HREG_W'(480);

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_sel_t;

  // floor(t / AREA) as (t * DIV_MUL) >> DIV_SHIFT, exact for t <= AREA * PIX_MAX
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MUL   = ((1 << DIV_SHIFT) + AREA - 1) / AREA;
  localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);
  localparam int PROD_W    = TOTAL_W + DIV_MUL_W;

  // Link from one window cell to the next
  typedef struct packed {
    logic              shift;
    logic [CSUM_W-1:0] sum;
  } cell_link_t;

  // Position info carried along with an item
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

>>> rtl/core/bf7_ram.sv
module bf7_ram #(
  parameter int DATA_W  = 8,
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  logic [DATA_W-1:0]          wdata,
  input  logic                       re,
  input  logic [$clog2(ENTRIES)-1:0] raddr,
  output logic [DATA_W-1:0]          rdata
);

  logic [DATA_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bf7_cell.sv
module bf7_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  bf7_pkg::cell_link_t       link_in,
  output logic [bf7_pkg::CSUM_W-1:0] value
);

  import bf7_pkg::*;

  // Hold one column sum; take the sum on the incoming link on every shift
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (link_in.shift) begin
      value <= link_in.sum;
    end
  end

endmodule

>>> rtl/core/box_filter_7x7_stream.sv
// Streaming 7x7 box filter for 8-bit greyscale pixels in raster order. Feed one
// pixel per transfer, with frame_start high on the first pixel of a frame; the
// block takes one pixel every clock while the output side keeps up. For each
// pixel at (r,c) with r >= 6 and c >= 6 it gives one result: the mean of the
// 7x7 window ending there, rounded down, tagged with its center (r-3,c-3) and
// with last set on the final interior pixel of the frame. Border pixels are not
// produced; fill them downstream. A result passes stages A, B and C before it
// enters the output register; the line store (a 1024 x 48 bit memory with
// one read and one write each clock) and the seven-cell column-sum chain each
// handle one pixel per clock, so the rate is one pixel per clock when unstalled.
// Program image_width (byte address 0) and image_height (byte address 4) only
// while the block is idle; values outside 7..1024 and 7..4096 act as clamped.
module box_filter_7x7_stream (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bf7_pkg::PADDR_W-1:0]  paddr,
  input  logic [bf7_pkg::PDATA_W-1:0]  pwdata,
  output logic [bf7_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // pixel input
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bf7_pkg::PIX_W-1:0]    pixel,
  input  logic                         frame_start,
  // result output
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bf7_pkg::PIX_W-1:0]    smoothed,
  output logic [bf7_pkg::ROW_W-1:0]    out_row,
  output logic [bf7_pkg::COL_W-1:0]    out_col,
  output logic                         last
);

  import bf7_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [WREG_W-1:0] image_width;
  logic [HREG_W-1:0] image_height;
  logic              cfg_write;
  reg_sel_t          cfg_sel;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_sel_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WREG_RESET;
      image_height <= HREG_RESET;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_WIDTH:  image_width  <= pwdata[WREG_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HREG_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  // Clamp the programmed size into the supported range
  logic [WREG_W-1:0] w_used;
  logic [HREG_W-1:0] h_used;

  always_comb begin
    if (image_width < WREG_W'(WINDOW)) begin
      w_used = WREG_W'(WINDOW);
    end else if (image_width > WREG_W'(MAX_WIDTH)) begin
      w_used = WREG_W'(MAX_WIDTH);
    end else begin
      w_used = image_width;
    end
    if (image_height < HREG_W'(WINDOW)) begin
      h_used = HREG_W'(WINDOW);
    end else if (image_height > HREG_W'(MAX_HEIGHT)) begin
      h_used = HREG_W'(MAX_HEIGHT);
    end else begin
      h_used = image_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // Stage A holds the accepted pixel while its line-store word comes back,
  // stage B sums the window, stage C divides, then the output register.
  // Each stage frees up when its occupant moves on in the same clock, so a
  // full pipeline keeps streaming as long as the output transfer happens.
  // ---------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid;
  logic a_go, b_go, c_go;
  logic a_free, b_free, c_free, d_free;
  logic accept;
  pos_t b_pos;

  assign d_free   = !out_valid || !out_stall;
  assign c_go     = c_valid && d_free;
  assign c_free   = !c_valid || d_free;
  // drop items that produce no result as they leave stage B
  assign b_go     = b_valid && (!b_pos.emit || c_free);
  assign b_free   = !b_valid || b_go;
  assign a_go     = a_valid && b_free;
  assign a_free   = !a_valid || a_go;
  assign in_stall = !a_free;
  assign accept   = in_valid && a_free;

  // ---------------------------------------------------------------------------
  // Position tracking at the input transfer
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [COL_W-1:0]  col_count, col_count_next;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;
  logic              wrap_col, wrap_row;
  pos_t              in_pos;

  always_comb begin
    // frame start restarts the position before this pixel is placed
    cur_row = frame_start ? '0 : row_count;
    cur_col = frame_start ? '0 : col_count;

    col_inc  = {1'b0, cur_col} + (COL_W + 1)'(1);
    row_inc  = {1'b0, cur_row} + (ROW_W + 1)'(1);
    // "at or beyond" so a position past a shrunken size wraps at once
    wrap_col = col_inc >= w_used;
    wrap_row = row_inc >= h_used;

    if (wrap_col) begin
      col_count_next = '0;
      row_count_next = wrap_row ? '0 : row_inc[ROW_W-1:0];
    end else begin
      col_count_next = col_inc[COL_W-1:0];
      row_count_next = cur_row;
    end

    in_pos.emit = (cur_row >= ROW_W'(LINE_DEPTH)) && (cur_col >= COL_W'(LINE_DEPTH));
    in_pos.last = ({1'b0, cur_row} == h_used - HREG_W'(1)) &&
                  ({1'b0, cur_col} == w_used - WREG_W'(1));
    in_pos.row  = cur_row - ROW_W'(HALF);
    in_pos.col  = cur_col - COL_W'(HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= row_count_next;
      col_count <= col_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: line store read and vertical column sum
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]  a_pix;
  logic [COL_W-1:0]  a_col;
  pos_t              a_pos;
  logic              a_fwd;
  logic [LINE_W-1:0] a_fwd_line;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] a_stored;
  logic [LINE_W-1:0] a_line_new;
  logic [CSUM_W-1:0] a_colsum;
  logic              fwd_hit;

  // The store word is read at the transfer edge. If the item leaving stage A
  // writes the same column at that edge (back-to-back frame starts), the read
  // sees the old word, so capture the fresh word alongside the pixel instead.
  assign fwd_hit = a_go && (a_col == cur_col);

  bf7_ram #(
    .DATA_W  (LINE_W),
    .ENTRIES (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (a_go),
    .waddr (a_col),
    .wdata (a_line_new),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix      <= pixel;
      a_col      <= cur_col;
      a_pos      <= in_pos;
      a_fwd      <= fwd_hit;
      a_fwd_line <= a_line_new;
    end
  end

  always_comb begin
    a_stored = a_fwd ? a_fwd_line : ram_rdata;
    // drop the oldest pixel of the column, append the new one on top
    a_line_new = {a_pix, a_stored[LINE_W-1:PIX_W]};
    a_colsum   = CSUM_W'(a_pix);
    for (int i = 0; i < LINE_DEPTH; i++) begin
      a_colsum = a_colsum + CSUM_W'(a_stored[i*PIX_W +: PIX_W]);
    end
  end

  // ---------------------------------------------------------------------------
  // Column-sum chain: the newest sum enters the top cell, every cell passes
  // its value one place down on each stage A transfer.
  // ---------------------------------------------------------------------------
  logic [CSUM_W-1:0] cell_value [WINDOW];
  cell_link_t        cell_link  [WINDOW];

  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    assign cell_link[g].shift = a_go;
    if (g == WINDOW - 1) begin : g_top
      assign cell_link[g].sum = a_colsum;
    end else begin : g_inner
      assign cell_link[g].sum = cell_value[g+1];
    end

    bf7_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .link_in (cell_link[g]),
      .value   (cell_value[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage B: horizontal sum of the window
  // ---------------------------------------------------------------------------
  logic [TOTAL_W-1:0] b_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_go) begin
      b_valid <= 1'b1;
    end else if (b_go) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go) begin
      b_pos <= a_pos;
    end
  end

  always_comb begin
    b_total = '0;
    for (int i = 0; i < WINDOW; i++) begin
      b_total = b_total + TOTAL_W'(cell_value[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: divide by the window area through a reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [TOTAL_W-1:0] c_total;
  pos_t               c_pos;
  logic [PROD_W-1:0]  c_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (b_go && b_pos.emit) begin
      c_valid <= 1'b1;
    end else if (c_go) begin
      c_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_pos.emit) begin
      c_total <= b_total;
      c_pos   <= b_pos;
    end
  end

  assign c_prod = PROD_W'(c_total) * PROD_W'(DIV_MUL);

  // ---------------------------------------------------------------------------
  // Output register: hold the result until its transfer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_go) begin
      out_valid <= 1'b1;
    end else if (d_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_go) begin
      smoothed <= c_prod[DIV_SHIFT +: PIX_W];
      out_row  <= c_pos.row;
      out_col  <= c_pos.col;
      last     <= c_pos.last;
    end
  end

endmodule

>>> rtl/core/bf7_checker.sv
module bf7_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bf7_pkg::PIX_W-1:0]   smoothed,
  input logic [bf7_pkg::ROW_W-1:0]   out_row,
  input logic [bf7_pkg::COL_W-1:0]   out_col,
  input logic                        last
);

  import bf7_pkg::*;

  // A stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(smoothed) && $stable(out_row) &&
                               $stable(out_col) && $stable(last))
  else $error("stalled result changed");

  // Reset empties the output register
  assert property (@(posedge clk)
    rst |=> !out_valid)
  else $error("result present after reset");

  // Only interior pixels come out
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row >= ROW_W'(HALF)) && (out_col >= COL_W'(HALF)))
  else $error("border pixel emitted");

  // With the output register empty the whole pipeline can advance
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
  else $error("input stalled with empty output");

endmodule

bind box_filter_7x7_stream bf7_checker u_bf7_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .smoothed  (smoothed),
  .out_row   (out_row),
  .out_col   (out_col),
  .last      (last)
);
